>>> rtl/addressed_frame_receiver_xor_check_assert.svh
// Assertion macros for the addressed frame receiver.
// Depends on a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef ADDRESSED_FRAME_RECEIVER_XOR_CHECK_ASSERT_SVH
`define ADDRESSED_FRAME_RECEIVER_XOR_CHECK_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AFRX_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("afrx: implication check failed");

// Next-cycle implication, checked outside reset.
`define AFRX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("afrx: next-cycle check failed");

`endif

>>> rtl/afrx_pkg.sv
// Shared constants and controller/datapath interface types of the frame receiver.
// No dependencies.
package afrx_pkg;

	localparam int MAX_PAYLOAD_DEF = 15;

	localparam int BYTE_W = 8;
	localparam int NIB_W  = 4;
	localparam int REM_W  = 5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic rx_take;
		logic emit_load;
	} afrx_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic chk_pass;
		logic emit_last;
		logic out_hold;
	} afrx_sts_t;

endpackage

>>> rtl/afrx_ctrl.sv
// Controller of the frame receiver: receive and emit phases.
// Depends on afrx_pkg.
module afrx_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  afrx_pkg::afrx_sts_t sts,
	output logic                in_stall,
	output afrx_pkg::afrx_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_RX   = 2'b01,
		ST_EMIT = 2'b10
	} afrx_state_t;

	afrx_state_t state_q;
	afrx_state_t state_d;

	always_comb begin
		state_d       = state_q;
		in_stall      = 1'b1;
		cmd.rx_take   = 1'b0;
		cmd.emit_load = 1'b0;
		unique case (state_q)
			ST_RX: begin
				in_stall    = 1'b0;
				cmd.rx_take = in_valid;
				if (in_valid && sts.chk_pass) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit_load = !sts.out_hold;
				if (!sts.out_hold && sts.emit_last) begin
					state_d = ST_RX;
				end
			end
			default: begin
				state_d = ST_RX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RX;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/afrx_dp.sv
// Datapath of the frame receiver: frame counters, checksum, payload store, output register.
// Depends on afrx_pkg.
module afrx_dp #(
	parameter int MAX_PAYLOAD = afrx_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [afrx_pkg::NIB_W-1:0]    cfg_wr_data,
	input  logic [afrx_pkg::BYTE_W-1:0]   rx_byte,
	input  logic                          out_stall,
	input  afrx_pkg::afrx_cmd_t           cmd,
	output afrx_pkg::afrx_sts_t           sts,
	output logic                          out_valid,
	output logic [afrx_pkg::NIB_W-1:0]    frame_length,
	output logic                          payload_valid,
	output logic [afrx_pkg::NIB_W-1:0]    payload_index,
	output logic [afrx_pkg::BYTE_W-1:0]   payload_byte,
	output logic                          last
);

	localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [afrx_pkg::NIB_W-1:0] MAX_N = afrx_pkg::NIB_W'(MAX_PAYLOAD);

	logic [afrx_pkg::NIB_W-1:0]  node_id_q;
	logic [afrx_pkg::REM_W-1:0]  rem_q;
	logic [afrx_pkg::BYTE_W-1:0] xor_q;
	logic [afrx_pkg::NIB_W-1:0]  dest_q;
	logic [afrx_pkg::NIB_W-1:0]  len_q;
	logic [afrx_pkg::NIB_W-1:0]  wr_idx_q;
	logic [afrx_pkg::NIB_W-1:0]  emit_k_q;
	logic                        out_valid_q;
	logic [afrx_pkg::NIB_W-1:0]  frame_length_q;
	logic                        payload_valid_q;
	logic [afrx_pkg::NIB_W-1:0]  payload_index_q;
	logic [afrx_pkg::BYTE_W-1:0] payload_byte_q;
	logic                        last_q;
	logic [afrx_pkg::BYTE_W-1:0] store_q [MAX_PAYLOAD];

	logic                       match;
	logic                       is_hdr;
	logic                       is_pay;
	logic [afrx_pkg::NIB_W-1:0] count;

	assign match  = (dest_q == node_id_q);
	assign is_hdr = (rem_q == '0);
	assign is_pay = (rem_q > afrx_pkg::REM_W'(1));
	assign count  = (len_q < MAX_N) ? len_q : MAX_N;

	assign sts.chk_pass  = (rem_q == afrx_pkg::REM_W'(1)) && match && (xor_q == rx_byte);
	assign sts.emit_last = (len_q == '0) || (emit_k_q == count - afrx_pkg::NIB_W'(1));
	assign sts.out_hold  = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= '0;
		end else if (cfg_wr_en) begin
			node_id_q <= cfg_wr_data;
		end
	end

	// Frame tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			xor_q    <= '0;
			dest_q   <= '0;
			len_q    <= '0;
			wr_idx_q <= '0;
			emit_k_q <= '0;
		end else begin
			if (cmd.rx_take) begin
				if (is_hdr) begin
					xor_q    <= rx_byte;
					len_q    <= rx_byte[afrx_pkg::NIB_W-1:0];
					dest_q   <= rx_byte[afrx_pkg::BYTE_W-1:afrx_pkg::NIB_W];
					rem_q    <= {1'b0, rx_byte[afrx_pkg::NIB_W-1:0]} + afrx_pkg::REM_W'(1);
					wr_idx_q <= '0;
				end else if (is_pay) begin
					if (match) begin
						xor_q    <= xor_q ^ rx_byte;
						wr_idx_q <= wr_idx_q + afrx_pkg::NIB_W'(1);
					end
					rem_q <= rem_q - afrx_pkg::REM_W'(1);
				end else begin
					rem_q    <= '0;
					emit_k_q <= '0;
				end
			end
			if (cmd.emit_load) begin
				emit_k_q <= emit_k_q + afrx_pkg::NIB_W'(1);
			end
		end
	end

	// Payload store; bytes past the store depth are dropped.
	always_ff @(posedge clk) begin
		if (cmd.rx_take && is_pay && match && (wr_idx_q < MAX_N)) begin
			store_q[wr_idx_q[IDX_W-1:0]] <= rx_byte;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload, store read registered here.
	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			frame_length_q  <= len_q;
			payload_valid_q <= (len_q != '0);
			payload_index_q <= emit_k_q;
			payload_byte_q  <= (len_q == '0) ? '0 : store_q[emit_k_q[IDX_W-1:0]];
			last_q          <= sts.emit_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_length  = frame_length_q;
	assign payload_valid = payload_valid_q;
	assign payload_index = payload_index_q;
	assign payload_byte  = payload_byte_q;
	assign last          = last_q;

endmodule

>>> rtl/addressed_frame_receiver_xor_check.sv
// Top level of the addressed frame receiver with XOR checksum.
// Depends on afrx_pkg, afrx_ctrl, afrx_dp and the assertion macro header.
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) carries one bus byte per beat.
//   A frame is a header byte (destination id in the high nibble, payload length in
//   the low nibble), that many payload bytes and one XOR checksum byte covering
//   header and payload. Frames whose destination equals own_node_id are stored;
//   others are counted off. own_node_id must be written through cfg_wr_en /
//   cfg_wr_data while the block is idle; the block itself does not enforce this.
//   Output channel (out_valid / out_stall) carries one payload byte per beat with
//   frame_length, payload_index and last; an empty frame gives one beat with
//   payload_valid low and last high. Bad-checksum frames give no beats.
//   Throughput: header and payload bytes are taken one per cycle. A passing
//   checksum byte starts the emit phase: min(length, MAX_PAYLOAD) beats (one for
//   an empty frame) at one per cycle while out_stall is low, set by the single
//   store read port; in_stall stays high for the whole emit phase.
//   Emit start: the checksum byte sets ST_EMIT; the emit load then raises out_valid.
//   Receiver stall: out_stall holds the output register and freezes the emit phase.
//   Reset: clears node id, frame tracking and output valid; the block waits for a
//   header. The payload store is not cleared.
`include "addressed_frame_receiver_xor_check_assert.svh"

module addressed_frame_receiver_xor_check #(
	parameter int MAX_PAYLOAD = afrx_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [afrx_pkg::NIB_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [afrx_pkg::BYTE_W-1:0] rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [afrx_pkg::NIB_W-1:0]  frame_length,
	output logic                        payload_valid,
	output logic [afrx_pkg::NIB_W-1:0]  payload_index,
	output logic [afrx_pkg::BYTE_W-1:0] payload_byte,
	output logic                        last
);

	afrx_pkg::afrx_cmd_t cmd;
	afrx_pkg::afrx_sts_t sts;

	// Controller: decide when to take a byte and when to load a result.
	afrx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// Datapath: frame state, checksum, store and output register.
	afrx_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.rx_byte       (rx_byte),
		.out_stall     (out_stall),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.frame_length  (frame_length),
		.payload_valid (payload_valid),
		.payload_index (payload_index),
		.payload_byte  (payload_byte),
		.last          (last)
	);

	// A passing checksum byte must block input while the run is emitted.
	`AFRX_ASSERT_NEXT(a_pass_stalls, in_valid && !in_stall && sts.chk_pass, in_stall)
	// A non-final beat taken is followed at once by the next beat of the run.
	`AFRX_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !last, out_valid)
	// An empty-frame beat is the whole run.
	`AFRX_ASSERT_IMPL(a_empty_is_last, out_valid && !payload_valid, last && frame_length == '0)
	// A data beat lies inside the frame.
	`AFRX_ASSERT_IMPL(a_index_in_frame, out_valid && payload_valid, payload_index < frame_length)

endmodule
